// ===== sv/ptrd_pkg.sv =====
package ptrd_pkg;

  localparam int CAPACITY   = 1024;
  localparam int NUM_TABLES = 3;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TBL_W      = 2;
  localparam int ADDR_W     = TBL_W + IDX_W;
  localparam int DEPTH      = NUM_TABLES * CAPACITY;
  localparam int COORD_W    = 16;
  localparam int RADIUS_W   = 15;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int ATTR_W     = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_KIND = 2'd2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [ATTR_W-1:0]         attributes;
  } entry_t;

endpackage

// ===== sv/ptrd_if.sv =====
interface ptrd_cmd_if;
  import ptrd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             opcode;
  logic [TBL_W-1:0]            kind;
  logic signed [COORD_W-1:0]   pos_x;
  logic signed [COORD_W-1:0]   pos_y;
  logic signed [COORD_W-1:0]   pos_z;
  logic [ATTR_W-1:0]           attributes;
  logic [CNT_W-1:0]            how_many;
  logic signed [COORD_W-1:0]   center_x;
  logic signed [COORD_W-1:0]   center_y;
  logic [RADIUS_W-1:0]         radius;

  modport source (
    output valid, opcode, kind, pos_x, pos_y, pos_z, attributes, how_many,
           center_x, center_y, radius,
    input  ready
  );
  modport sink (
    input  valid, opcode, kind, pos_x, pos_y, pos_z, attributes, how_many,
           center_x, center_y, radius,
    output ready
  );
endinterface

interface ptrd_res_if;
  import ptrd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    count_after;
  logic [CNT_W-1:0]    removed;

  modport source (output valid, status, count_after, removed, input ready);
  modport sink   (input valid, status, count_after, removed, output ready);
endinterface

// ===== sv/ptrd_ram.sv =====
module ptrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/ptrd_dist.sv =====
module ptrd_dist (
  input  logic                              clk,
  input  logic signed [ptrd_pkg::COORD_W-1:0] ent_x,
  input  logic signed [ptrd_pkg::COORD_W-1:0] ent_y,
  input  logic signed [ptrd_pkg::COORD_W-1:0] cx,
  input  logic signed [ptrd_pkg::COORD_W-1:0] cy,
  input  logic [ptrd_pkg::R2_W-1:0]         r2,
  output logic                              hit
);
  import ptrd_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] prod_x;
  logic signed [2*COORD_W+1:0] prod_y;
  logic [2*COORD_W-1:0]        sq_x;
  logic [2*COORD_W-1:0]        sq_y;
  logic [2*COORD_W:0]          sum;

  // stage 1: differences, stage 2: squares, then add and compare
  always_ff @(posedge clk) begin
    dx <= {ent_x[COORD_W-1], ent_x} - {cx[COORD_W-1], cx};
    dy <= {ent_y[COORD_W-1], ent_y} - {cy[COORD_W-1], cy};
  end

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    sq_x <= prod_x[2*COORD_W-1:0];
    sq_y <= prod_y[2*COORD_W-1:0];
  end

  assign sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit = sum <= {{(2*COORD_W+1-R2_W){1'b0}}, r2};
endmodule

// ===== sv/particle_table_radius_delete.sv =====
// Channel | Dir | Payload
// cmd     | in  | opcode, kind, pos_x/y/z, attributes, how_many, center_x/y, radius
// res     | out | status, count_after, removed
//
// Append, remove-from-end, unknown kind and unused opcode go from idle straight to done;
// delete-in-radius walks each entry through read, W1, W2, W3 and, on a hit that is not the last
// entry, a swap copy; the entry memory (read, 2-stage distance pipe, then copy) sets its pace.
// rst is synchronous; it empties all tables, no memory clearing pass.
// A result waits in the output register; one more item may be taken meanwhile.
module particle_table_radius_delete (
  input  logic        clk,
  input  logic        rst,
  ptrd_cmd_if.sink    cmd,
  ptrd_res_if.source  res
);
  import ptrd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_W1   = 3'd2;
  localparam logic [2:0] S_W2   = 3'd3;
  localparam logic [2:0] S_W3   = 3'd4;
  localparam logic [2:0] S_CP   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                state;
  cnt_t                      cnt [NUM_TABLES];
  logic [TBL_W-1:0]          kind_r;
  cnt_t                      idx;
  cnt_t                      removed_r;
  cnt_t                      res_cnt;
  logic [STATUS_W-1:0]       status_r;
  logic signed [COORD_W-1:0] cx_r;
  logic signed [COORD_W-1:0] cy_r;
  logic [R2_W-1:0]           r2_r;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  cnt_t                out_cnt;
  cnt_t                out_removed;

  logic   accept;
  logic   kind_ok;
  logic   load_out;
  cnt_t   cur;
  cnt_t   walk_cnt;
  cnt_t   last;
  cnt_t   rem;
  logic   has_room;
  logic   hit;
  logic   we;
  logic   re;
  addr_t  waddr;
  addr_t  raddr;
  entry_t wdata;
  entry_t rdata;
  entry_t new_entry;

  assign cmd.ready = state == S_IDLE;
  assign accept    = cmd.valid && cmd.ready;
  assign kind_ok   = cmd.kind < TBL_W'(NUM_TABLES);
  assign load_out  = state == S_DONE && (!out_valid || res.ready);

  always_comb begin
    case (cmd.kind)
      2'd0:    cur = cnt[0];
      2'd1:    cur = cnt[1];
      2'd2:    cur = cnt[2];
      default: cur = '0;
    endcase
    case (kind_r)
      2'd0:    walk_cnt = cnt[0];
      2'd1:    walk_cnt = cnt[1];
      2'd2:    walk_cnt = cnt[2];
      default: walk_cnt = '0;
    endcase
  end

  assign last     = walk_cnt - cnt_t'(1);
  assign has_room = cur < cnt_t'(CAPACITY);
  assign rem      = (cmd.how_many < cur) ? cmd.how_many : cur;

  assign new_entry.pos_x      = cmd.pos_x;
  assign new_entry.pos_y      = cmd.pos_y;
  assign new_entry.pos_z      = cmd.pos_z;
  assign new_entry.attributes = cmd.attributes;

  always_comb begin
    we    = 1'b0;
    waddr = {cmd.kind, cur[IDX_W-1:0]};
    wdata = new_entry;
    if (state == S_CP) begin
      we    = 1'b1;
      waddr = {kind_r, idx[IDX_W-1:0]};
      wdata = rdata;
    end else if (accept && kind_ok && cmd.opcode == OP_APPEND && has_room) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = {kind_r, idx[IDX_W-1:0]};
    if (state == S_RD) begin
      re = idx < walk_cnt;
    end else if (state == S_W3 && hit && idx != last) begin
      re    = 1'b1;
      raddr = {kind_r, last[IDX_W-1:0]};
    end
  end

  ptrd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ptrd_dist u_dist (
    .clk   (clk),
    .ent_x (rdata.pos_x),
    .ent_y (rdata.pos_y),
    .cx    (cx_r),
    .cy    (cy_r),
    .r2    (r2_r),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < NUM_TABLES; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r    <= cmd.kind;
            status_r  <= ST_OK;
            removed_r <= '0;
            res_cnt   <= cur;
            state     <= S_DONE;
            if (!kind_ok) begin
              status_r <= ST_BAD_KIND;
              res_cnt  <= '0;
            end else begin
              case (cmd.opcode)
                OP_APPEND: begin
                  if (has_room) begin
                    res_cnt <= cur + cnt_t'(1);
                    for (int k = 0; k < NUM_TABLES; k++) begin
                      if (TBL_W'(k) == cmd.kind) begin
                        cnt[k] <= cur + cnt_t'(1);
                      end
                    end
                  end else begin
                    status_r <= ST_FULL;
                  end
                end
                OP_REMOVE: begin
                  removed_r <= rem;
                  res_cnt   <= cur - rem;
                  for (int k = 0; k < NUM_TABLES; k++) begin
                    if (TBL_W'(k) == cmd.kind) begin
                      cnt[k] <= cur - rem;
                    end
                  end
                end
                OP_DELETE: begin
                  cx_r  <= cmd.center_x;
                  cy_r  <= cmd.center_y;
                  r2_r  <= cmd.radius * cmd.radius;
                  idx   <= '0;
                  state <= S_RD;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_RD: begin
          if (idx < walk_cnt) begin
            state <= S_W1;
          end else begin
            res_cnt <= walk_cnt;
            state   <= S_DONE;
          end
        end
        S_W1: state <= S_W2;
        S_W2: state <= S_W3;
        S_W3: begin
          if (hit) begin
            removed_r <= removed_r + cnt_t'(1);
            for (int k = 0; k < NUM_TABLES; k++) begin
              if (TBL_W'(k) == kind_r) begin
                cnt[k] <= last;
              end
            end
            state <= (idx != last) ? S_CP : S_RD;
          end else begin
            idx   <= idx + cnt_t'(1);
            state <= S_RD;
          end
        end
        S_CP: state <= S_RD;
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid   <= 1'b1;
      out_status  <= status_r;
      out_cnt     <= res_cnt;
      out_removed <= removed_r;
    end else if (res.valid && res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.count_after = out_cnt;
  assign res.removed     = out_removed;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= cnt_t'(CAPACITY) && cnt[1] <= cnt_t'(CAPACITY) && cnt[2] <= cnt_t'(CAPACITY))
    else $error("table count above capacity");

  a_walk_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_W1 || state == S_W2 || state == S_W3 || state == S_CP) |-> idx < walk_cnt)
    else $error("delete walk index past table end");

  a_bad_kind_stable: assert property (@(posedge clk) disable iff (rst)
    accept && !kind_ok |=> $stable(cnt[0]) && $stable(cnt[1]) && $stable(cnt[2]))
    else $error("unknown kind changed a count");

  a_full_no_remove: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |-> res.removed == '0)
    else $error("error result reports removed entries");

  a_copy_after_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_CP |-> $past(state == S_W3 && hit))
    else $error("copy without a hit");
`endif
endmodule

// ===== sim/tb_particle_table_radius_delete.sv =====
module tb_particle_table_radius_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrd_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
  localparam logic [TBL_W-1:0] KIND_BASIC    = 2'd0;
  localparam logic [TBL_W-1:0] KIND_PREDATOR = 2'd1;
  localparam logic [TBL_W-1:0] KIND_OBSTACLE = 2'd2;
  localparam logic [TBL_W-1:0] KIND_BAD      = 2'd3;

  localparam int MAX_CYCLES   = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 120;
  localparam int HIGH_WATER   = 80;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [TBL_W-1:0]          tbl;
    entry_t                    ent;
    cnt_t                      how_many;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RADIUS_W-1:0]       radius;
  } table_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    cnt_t                count_after;
    cnt_t                removed;
  } table_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptrd_cmd_if cmd ();
  ptrd_res_if res ();

  particle_table_radius_delete u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  entry_t      table_mem [NUM_TABLES][CAPACITY];
  int          table_count [NUM_TABLES];
  table_res_t  expected_q [$];
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] cluster_coord();
    return 16'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  // Table model: swap-with-last removal, same slot tested again.
  function automatic table_res_t apply_cmd(table_cmd_t c);
    table_res_t r;
    int         t;
    int         i;
    longint     dx;
    longint     dy;
    longint     r2;
    r = '0;
    t = c.tbl;
    if (c.tbl == KIND_BAD) begin
      r.status = ST_BAD_KIND;
      return r;
    end
    case (c.op)
      OP_APPEND: begin
        if (table_count[t] >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          table_mem[t][table_count[t]] = c.ent;
          table_count[t]++;
        end
      end
      OP_REMOVE: begin
        r.removed = (c.how_many < table_count[t]) ? c.how_many : cnt_t'(table_count[t]);
        table_count[t] -= r.removed;
      end
      OP_DELETE: begin
        r2 = longint'(c.radius) * longint'(c.radius);
        i = 0;
        while (i < table_count[t]) begin
          dx = longint'($signed(table_mem[t][i].pos_x)) - longint'($signed(c.cx));
          dy = longint'($signed(table_mem[t][i].pos_y)) - longint'($signed(c.cy));
          if (dx * dx + dy * dy <= r2) begin
            table_mem[t][i] = table_mem[t][table_count[t] - 1];
            table_count[t]--;
            r.removed++;
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    r.count_after = cnt_t'(table_count[t]);
    return r;
  endfunction

  // Unused fields stay random.
  function automatic table_cmd_t make_cmd(logic [OP_W-1:0] op, logic [TBL_W-1:0] tbl);
    table_cmd_t c;
    c.op             = op;
    c.tbl            = tbl;
    c.ent.pos_x      = 16'($urandom);
    c.ent.pos_y      = 16'($urandom);
    c.ent.pos_z      = 16'($urandom);
    c.ent.attributes = $urandom;
    c.how_many       = 11'($urandom);
    c.cx             = 16'($urandom);
    c.cy             = 16'($urandom);
    c.radius         = 15'($urandom);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 50)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_item(table_cmd_t c);
    int         gap;
    table_res_t want;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.opcode     <= c.op;
    cmd.kind       <= c.tbl;
    cmd.pos_x      <= c.ent.pos_x;
    cmd.pos_y      <= c.ent.pos_y;
    cmd.pos_z      <= c.ent.pos_z;
    cmd.attributes <= c.ent.attributes;
    cmd.how_many   <= c.how_many;
    cmd.center_x   <= c.cx;
    cmd.center_y   <= c.cy;
    cmd.radius     <= c.radius;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    want = apply_cmd(c);
    expected_q.insert(expected_q.size(), want);
  endtask

  task automatic send_append(logic [TBL_W-1:0] tbl, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                             logic [ATTR_W-1:0] attr);
    table_cmd_t c;
    c = make_cmd(OP_APPEND, tbl);
    c.ent = {x, y, z, attr};
    send_item(c);
  endtask

  task automatic send_remove(logic [TBL_W-1:0] tbl, cnt_t n);
    table_cmd_t c;
    c = make_cmd(OP_REMOVE, tbl);
    c.how_many = n;
    send_item(c);
  endtask

  task automatic send_delete(logic [TBL_W-1:0] tbl, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic [RADIUS_W-1:0] r);
    table_cmd_t c;
    c = make_cmd(OP_DELETE, tbl);
    c.cx     = x;
    c.cy     = y;
    c.radius = r;
    send_item(c);
  endtask

  task automatic wait_all_results();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    entry_t     pick;
    int         roll;
    int         t;
    int         n;
    t    = $urandom_range(0, NUM_TABLES - 1);
    n    = table_count[t];
    roll = $urandom_range(0, 99);
    c    = make_cmd(OP_APPEND, KIND_BAD);
    if (roll < 3) begin
      c.op = OP_W'($urandom);
      return c;
    end
    c.tbl = TBL_W'(t);
    if (roll < 6) begin
      c.op = OP_UNUSED;
    end else if (roll < 20) begin
      c.op = OP_REMOVE;
      roll = $urandom_range(0, 99);
      if (roll < 80)      c.how_many = cnt_t'($urandom_range(0, 4));
      else if (roll < 95) c.how_many = cnt_t'($urandom_range(0, n + 2));
    end else if (roll < 45 || n >= HIGH_WATER) begin
      c.op = OP_DELETE;
      if (n > 0 && $urandom_range(0, 9) < 7) begin
        pick = table_mem[t][$urandom_range(0, n - 1)];
        c.cx = pick.pos_x + 16'(int'($urandom_range(0, 63)) - 32);
        c.cy = pick.pos_y + 16'(int'($urandom_range(0, 63)) - 32);
        roll = $urandom_range(0, 99);
        if (roll < 40)      c.radius = RADIUS_W'($urandom_range(0, 64));
        else if (roll < 80) c.radius = RADIUS_W'($urandom_range(0, 1500));
      end else if ($urandom_range(0, 1) == 0) begin
        c.cx     = cluster_coord();
        c.cy     = cluster_coord();
        c.radius = RADIUS_W'($urandom_range(0, 600));
      end
    end else if ($urandom_range(0, 1) == 0) begin
      c.ent.pos_x = cluster_coord();
      c.ent.pos_y = cluster_coord();
    end
    return c;
  endfunction

  task automatic test_directed_cases();
    send_append(KIND_BASIC, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    send_append(KIND_BASIC, -16'sh8000, -16'sh8000, -16'sh8000, 32'h0);
    send_append(KIND_PREDATOR, 16'sh0, 16'sh0, 16'sh0, 32'hA5A5_5A5A);
    send_append(KIND_OBSTACLE, 16'sd100, -16'sd100, 16'sd7, 32'h1234_5678);
    send_item(make_cmd(OP_APPEND, KIND_BAD));
    send_item(make_cmd(OP_REMOVE, KIND_BAD));
    send_item(make_cmd(OP_DELETE, KIND_BAD));
    send_item(make_cmd(OP_UNUSED, KIND_BAD));
    send_item(make_cmd(OP_UNUSED, KIND_BASIC));
    send_item(make_cmd(OP_UNUSED, KIND_OBSTACLE));
    // far corner sits outside the largest circle around the opposite corner
    send_delete(KIND_BASIC, -16'sh8000, -16'sh8000, 15'h7FFF);
    send_delete(KIND_PREDATOR, 16'sh0, 16'sh0, 15'h0);
    send_delete(KIND_PREDATOR, 16'sh0, 16'sh0, 15'h7FFF);
    send_remove(KIND_BASIC, 11'd0);
    send_append(KIND_BASIC, 16'sd16, 16'sd0, 16'sd1, 32'h1);
    send_append(KIND_BASIC, 16'sd0, -16'sd16, 16'sd2, 32'h2);
    send_append(KIND_BASIC, 16'sd11, 16'sd12, 16'sd3, 32'h3);
    // radius boundary: distance equal to radius goes, just beyond stays
    send_delete(KIND_BASIC, 16'sd0, 16'sd0, 15'd16);
    send_remove(KIND_PREDATOR, 11'h7FF);
    send_remove(KIND_OBSTACLE, 11'd1);
    send_append(KIND_OBSTACLE, 16'sd5, 16'sd5, 16'sd5, 32'h5);
    send_append(KIND_OBSTACLE, 16'sd6, 16'sd6, 16'sd6, 32'h6);
    send_remove(KIND_BASIC, 11'h7FF);
    send_delete(KIND_OBSTACLE, 16'sd5, 16'sd5, 15'd0);
  endtask

  task automatic test_table_full();
    send_remove(KIND_OBSTACLE, 11'h7FF);
    steady = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == CAPACITY / 2) steady = 1'b0;
      send_append(KIND_OBSTACLE, cluster_coord(), cluster_coord(), 16'($urandom), $urandom);
    end
    send_append(KIND_OBSTACLE, 16'sd1, 16'sd1, 16'sd1, 32'h1);
    send_delete(KIND_OBSTACLE, 16'sh0, 16'sh0, 15'h7FFF);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 20) steady = 1'b1;
      if (i % 60 == 40) steady = 1'b0;
      if (i == RANDOM_ITEMS / 2) wait_all_results();
      send_item(random_cmd());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      res.ready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      res.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    table_res_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with none pending, count_after", res.count_after, -1);
      end else begin
        want = expected_q.pop_front();
        if (res.status !== want.status)
          report_mismatch("status", res.status, want.status);
        if (res.count_after !== want.count_after)
          report_mismatch("count_after", res.count_after, want.count_after);
        if (res.removed !== want.removed)
          report_mismatch("removed", res.removed, want.removed);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cmd.valid      = 1'b0;
    cmd.opcode     = OP_APPEND;
    cmd.kind       = KIND_BASIC;
    cmd.pos_x      = '0;
    cmd.pos_y      = '0;
    cmd.pos_z      = '0;
    cmd.attributes = '0;
    cmd.how_many   = '0;
    cmd.center_x   = '0;
    cmd.center_y   = '0;
    cmd.radius     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    wait_all_results();
    test_table_full();
    wait_all_results();
    test_random_traffic();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== particle_table_radius_delete.f =====
sv/ptrd_pkg.sv
sv/ptrd_if.sv
sv/ptrd_ram.sv
sv/ptrd_dist.sv
sv/particle_table_radius_delete.sv
sim/tb_particle_table_radius_delete.sv
